>>> design/fcat_pkg.sv
package fcat_pkg;

    localparam int MAX_OBJ  = 64;
    localparam int MAX_MOR  = 256;
    localparam int MAX_COMP = 1024;

    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_ADD_OBJ  = 3'd1,
        CMD_ADD_MOR  = 3'd2,
        CMD_SET_ID   = 3'd3,
        CMD_ADD_COMP = 3'd4,
        CMD_VALIDATE = 3'd5,
        CMD_COMPOSE  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_EXEC, S_OUT,
        S_CMP_A, S_CMP_B,
        S_CLR,
        S_ID_A, S_ID_B, S_ID_C,
        S_ROW_A, S_ROW_B, S_ROW_C, S_ROW_D, S_ROW_E, S_ROW_F,
        S_PR_A, S_PR_B, S_PR_C, S_PR_D,
        S_AS_A, S_AS_B, S_AS_C, S_AS_D, S_AS_E, S_AS_F,
        S_IL_A, S_IL_B, S_IL_C, S_IL_D, S_IL_E, S_IL_F
    } state_t;

endpackage

>>> design/finite_category_table_checker.sv
// channel  | signals                         | contents
// s_axis   | tvalid tready tdata[47:0] tuser | one command request
// m_axis   | tvalid tready tdata[23:0]       | one result per request
//
// one request at a time: ready only in idle, result held until taken.
// table commands run in the exec state; compose reads the stored rows in turn until
// one matches. validate first clears a pair scratch memory (all mc*mc entries),
// then walks the tables through single read ports.
// reset clears the three counts; table contents are kept and never swept.
module finite_category_table_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // object_id, domain_object, codomain_object, outer_morphism,
    // inner_morphism, target_morphism, zero pad
    input  logic [47:0] s_axis_tdata,
    // cmd
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, new_id, is_valid, found, composite, zero pad
    output logic [23:0] m_axis_tdata
);

    fcat_pkg::state_t state_reg, state_next;

    logic [6:0]  oc_reg, oc_next;
    logic [8:0]  mc_reg, mc_next;
    logic [10:0] cc_reg, cc_next;
    logic [10:0] ia_reg, ia_next;
    logic [10:0] ib_reg, ib_next;

    fcat_pkg::cmd_t cmd_reg, cmd_next;
    logic [5:0] obj_reg, obj_next;
    logic [5:0] dom_reg, dom_next;
    logic [5:0] cod_reg, cod_next;
    logic [7:0] g_reg, g_next;
    logic [7:0] f_reg, f_next;
    logic [7:0] t_reg, t_next;

    logic [7:0] tg_reg, tg_next;
    logic [7:0] tf_reg, tf_next;
    logic [7:0] tr_reg, tr_next;
    logic [7:0] hj_reg, hj_next;
    logic [7:0] ares_reg, ares_next;
    logic [5:0] fdom_reg, fdom_next;
    logic [5:0] fcod_reg, fcod_next;
    logic [5:0] gcod_reg, gcod_next;
    logic [5:0] dg_reg, dg_next;

    fcat_pkg::status_t status_reg, status_next;
    logic [7:0] new_id_reg, new_id_next;
    logic       valid_reg, valid_next;
    logic       found_reg, found_next;
    logic [7:0] comp_reg, comp_next;

    // table memories
    logic [8:0]  id_mem [fcat_pkg::MAX_OBJ];
    logic [11:0] mor_mem [fcat_pkg::MAX_MOR];
    logic [23:0] row_mem [fcat_pkg::MAX_COMP];
    // pair scratch: {count, first result} per (g, f)
    logic [9:0]  pair_mem [fcat_pkg::MAX_MOR * fcat_pkg::MAX_MOR];

    logic [5:0]  id_addr;
    logic        id_we;
    logic [8:0]  id_wdata;
    logic [8:0]  id_q;
    logic [7:0]  mor_addr;
    logic        mor_we;
    logic [11:0] mor_wdata;
    logic [11:0] mor_q;
    logic [9:0]  row_addr;
    logic        row_we;
    logic [23:0] row_wdata;
    logic [23:0] row_q;
    logic [15:0] pair_addr;
    logic        pair_we;
    logic [9:0]  pair_wdata;
    logic [9:0]  pair_q;

    logic chk_ok;
    logic ia_ge_oc, ia_ge_mc, ia_ge_cc, ib_ge_mc, ib_ge_cc;
    logic clr_f_last, clr_g_last;
    logic row_hit;

    always_ff @(posedge aclk) begin
        if (id_we) begin
            id_mem[id_addr] <= id_wdata;
        end
        id_q <= id_mem[id_addr];
    end

    always_ff @(posedge aclk) begin
        if (mor_we) begin
            mor_mem[mor_addr] <= mor_wdata;
        end
        mor_q <= mor_mem[mor_addr];
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_addr] <= row_wdata;
        end
        row_q <= row_mem[row_addr];
    end

    always_ff @(posedge aclk) begin
        if (pair_we) begin
            pair_mem[pair_addr] <= pair_wdata;
        end
        pair_q <= pair_mem[pair_addr];
    end

    assign ia_ge_oc   = ia_reg >= {4'd0, oc_reg};
    assign ia_ge_mc   = ia_reg >= {2'd0, mc_reg};
    assign ia_ge_cc   = ia_reg >= cc_reg;
    assign ib_ge_mc   = ib_reg >= {2'd0, mc_reg};
    assign ib_ge_cc   = ib_reg >= cc_reg;
    assign clr_f_last = (ib_reg + 11'd1) >= {2'd0, mc_reg};
    assign clr_g_last = (ia_reg + 11'd1) >= {2'd0, mc_reg};
    assign row_hit    = (row_q[23:16] == g_reg) && (row_q[15:8] == f_reg);

    // axiom check of the current step
    always_comb begin
        chk_ok = 1'b1;
        case (state_reg)
            fcat_pkg::S_ID_B: chk_ok = id_q[8] && ({1'b0, id_q[7:0]} < mc_reg);
            fcat_pkg::S_ID_C: chk_ok = (mor_q[11:6] == ia_reg[5:0])
                                    && (mor_q[5:0] == ia_reg[5:0]);
            fcat_pkg::S_ROW_B: chk_ok = ({1'b0, row_q[23:16]} < mc_reg)
                                     && ({1'b0, row_q[15:8]} < mc_reg)
                                     && ({1'b0, row_q[7:0]} < mc_reg);
            fcat_pkg::S_ROW_D: chk_ok = fcod_reg == mor_q[11:6];
            fcat_pkg::S_ROW_E: chk_ok = (mor_q[11:6] == fdom_reg)
                                     && (mor_q[5:0] == gcod_reg);
            fcat_pkg::S_PR_D: chk_ok = !((mor_q[5:0] == dg_reg) && (pair_q[9:8] != 2'd1));
            fcat_pkg::S_AS_F: chk_ok = pair_q[7:0] == ares_reg;
            fcat_pkg::S_IL_B: chk_ok = ({1'b0, mor_q[5:0]} < oc_reg)
                                    && ({1'b0, mor_q[11:6]} < oc_reg);
            fcat_pkg::S_IL_D, fcat_pkg::S_IL_F:
                chk_ok = (pair_q[9:8] == 2'd1) && (pair_q[7:0] == ia_reg[7:0]);
            default: chk_ok = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcat_pkg::S_IDLE;
            oc_reg    <= '0;
            mc_reg    <= '0;
            cc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            oc_reg    <= oc_next;
            mc_reg    <= mc_next;
            cc_reg    <= cc_next;
        end
    end

    always_ff @(posedge aclk) begin
        ia_reg     <= ia_next;
        ib_reg     <= ib_next;
        cmd_reg    <= cmd_next;
        obj_reg    <= obj_next;
        dom_reg    <= dom_next;
        cod_reg    <= cod_next;
        g_reg      <= g_next;
        f_reg      <= f_next;
        t_reg      <= t_next;
        tg_reg     <= tg_next;
        tf_reg     <= tf_next;
        tr_reg     <= tr_next;
        hj_reg     <= hj_next;
        ares_reg   <= ares_next;
        fdom_reg   <= fdom_next;
        fcod_reg   <= fcod_next;
        gcod_reg   <= gcod_next;
        dg_reg     <= dg_next;
        status_reg <= status_next;
        new_id_reg <= new_id_next;
        valid_reg  <= valid_next;
        found_reg  <= found_next;
        comp_reg   <= comp_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fcat_pkg::S_IDLE: if (s_axis_tvalid) state_next = fcat_pkg::S_EXEC;
            fcat_pkg::S_EXEC: begin
                unique case (cmd_reg)
                    fcat_pkg::CMD_VALIDATE:
                        state_next = (mc_reg == 9'd0) ? fcat_pkg::S_ID_A : fcat_pkg::S_CLR;
                    fcat_pkg::CMD_COMPOSE: state_next = fcat_pkg::S_CMP_A;
                    default: state_next = fcat_pkg::S_OUT;
                endcase
            end
            fcat_pkg::S_OUT: if (m_axis_tready) state_next = fcat_pkg::S_IDLE;
            fcat_pkg::S_CMP_A:
                state_next = ia_ge_cc ? fcat_pkg::S_OUT : fcat_pkg::S_CMP_B;
            fcat_pkg::S_CMP_B:
                state_next = row_hit ? fcat_pkg::S_OUT : fcat_pkg::S_CMP_A;
            fcat_pkg::S_CLR:
                if (clr_f_last && clr_g_last) state_next = fcat_pkg::S_ID_A;
            fcat_pkg::S_ID_A:
                state_next = ia_ge_oc ? fcat_pkg::S_ROW_A : fcat_pkg::S_ID_B;
            fcat_pkg::S_ID_B: state_next = chk_ok ? fcat_pkg::S_ID_C : fcat_pkg::S_OUT;
            fcat_pkg::S_ID_C: state_next = chk_ok ? fcat_pkg::S_ID_A : fcat_pkg::S_OUT;
            fcat_pkg::S_ROW_A:
                state_next = ia_ge_cc ? fcat_pkg::S_PR_A : fcat_pkg::S_ROW_B;
            fcat_pkg::S_ROW_B: state_next = chk_ok ? fcat_pkg::S_ROW_C : fcat_pkg::S_OUT;
            fcat_pkg::S_ROW_C: state_next = fcat_pkg::S_ROW_D;
            fcat_pkg::S_ROW_D: state_next = chk_ok ? fcat_pkg::S_ROW_E : fcat_pkg::S_OUT;
            fcat_pkg::S_ROW_E: state_next = chk_ok ? fcat_pkg::S_ROW_F : fcat_pkg::S_OUT;
            fcat_pkg::S_ROW_F: state_next = fcat_pkg::S_ROW_A;
            fcat_pkg::S_PR_A:
                state_next = ia_ge_mc ? fcat_pkg::S_AS_A : fcat_pkg::S_PR_B;
            fcat_pkg::S_PR_B: state_next = fcat_pkg::S_PR_C;
            fcat_pkg::S_PR_C:
                state_next = ib_ge_mc ? fcat_pkg::S_PR_A : fcat_pkg::S_PR_D;
            fcat_pkg::S_PR_D: state_next = chk_ok ? fcat_pkg::S_PR_C : fcat_pkg::S_OUT;
            fcat_pkg::S_AS_A:
                state_next = ia_ge_cc ? fcat_pkg::S_IL_A : fcat_pkg::S_AS_B;
            fcat_pkg::S_AS_B: state_next = fcat_pkg::S_AS_C;
            fcat_pkg::S_AS_C:
                state_next = ib_ge_cc ? fcat_pkg::S_AS_A : fcat_pkg::S_AS_D;
            fcat_pkg::S_AS_D:
                state_next = (row_q[15:8] == tg_reg) ? fcat_pkg::S_AS_E : fcat_pkg::S_AS_C;
            fcat_pkg::S_AS_E: state_next = fcat_pkg::S_AS_F;
            fcat_pkg::S_AS_F: state_next = chk_ok ? fcat_pkg::S_AS_C : fcat_pkg::S_OUT;
            fcat_pkg::S_IL_A:
                state_next = ia_ge_mc ? fcat_pkg::S_OUT : fcat_pkg::S_IL_B;
            fcat_pkg::S_IL_B: state_next = chk_ok ? fcat_pkg::S_IL_C : fcat_pkg::S_OUT;
            fcat_pkg::S_IL_C: state_next = fcat_pkg::S_IL_D;
            fcat_pkg::S_IL_D: state_next = chk_ok ? fcat_pkg::S_IL_E : fcat_pkg::S_OUT;
            fcat_pkg::S_IL_E: state_next = fcat_pkg::S_IL_F;
            fcat_pkg::S_IL_F: state_next = chk_ok ? fcat_pkg::S_IL_A : fcat_pkg::S_OUT;
            default: state_next = fcat_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        oc_next     = oc_reg;
        mc_next     = mc_reg;
        cc_next     = cc_reg;
        ia_next     = ia_reg;
        ib_next     = ib_reg;
        cmd_next    = cmd_reg;
        obj_next    = obj_reg;
        dom_next    = dom_reg;
        cod_next    = cod_reg;
        g_next      = g_reg;
        f_next      = f_reg;
        t_next      = t_reg;
        tg_next     = tg_reg;
        tf_next     = tf_reg;
        tr_next     = tr_reg;
        hj_next     = hj_reg;
        ares_next   = ares_reg;
        fdom_next   = fdom_reg;
        fcod_next   = fcod_reg;
        gcod_next   = gcod_reg;
        dg_next     = dg_reg;
        status_next = status_reg;
        new_id_next = new_id_reg;
        valid_next  = valid_reg;
        found_next  = found_reg;
        comp_next   = comp_reg;
        id_addr     = '0;
        id_we       = 1'b0;
        id_wdata    = '0;
        mor_addr    = '0;
        mor_we      = 1'b0;
        mor_wdata   = {dom_reg, cod_reg};
        row_addr    = '0;
        row_we      = 1'b0;
        row_wdata   = {g_reg, f_reg, t_reg};
        pair_addr   = '0;
        pair_we     = 1'b0;
        pair_wdata  = '0;

        unique case (state_reg)
            fcat_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                cmd_next = fcat_pkg::cmd_t'(s_axis_tuser);
                obj_next = s_axis_tdata[5:0];
                dom_next = s_axis_tdata[11:6];
                cod_next = s_axis_tdata[17:12];
                g_next   = s_axis_tdata[25:18];
                f_next   = s_axis_tdata[33:26];
                t_next   = s_axis_tdata[41:34];
            end
            fcat_pkg::S_EXEC: begin
                status_next = fcat_pkg::STAT_OK;
                new_id_next = '0;
                valid_next  = 1'b0;
                found_next  = 1'b0;
                comp_next   = '0;
                ia_next     = '0;
                ib_next     = '0;
                unique case (cmd_reg)
                    fcat_pkg::CMD_CLEAR: begin
                        oc_next = '0;
                        mc_next = '0;
                        cc_next = '0;
                    end
                    fcat_pkg::CMD_ADD_OBJ: begin
                        if (oc_reg >= 7'(fcat_pkg::MAX_OBJ)) begin
                            status_next = fcat_pkg::STAT_FULL;
                        end else begin
                            id_addr     = oc_reg[5:0];
                            id_we       = 1'b1;
                            new_id_next = {1'b0, oc_reg};
                            oc_next     = oc_reg + 7'd1;
                        end
                    end
                    fcat_pkg::CMD_ADD_MOR: begin
                        if (({1'b0, dom_reg} >= oc_reg) || ({1'b0, cod_reg} >= oc_reg)) begin
                            status_next = fcat_pkg::STAT_INVALID;
                        end else if (mc_reg >= 9'(fcat_pkg::MAX_MOR)) begin
                            status_next = fcat_pkg::STAT_FULL;
                        end else begin
                            mor_addr    = mc_reg[7:0];
                            mor_we      = 1'b1;
                            new_id_next = mc_reg[7:0];
                            mc_next     = mc_reg + 9'd1;
                        end
                    end
                    fcat_pkg::CMD_SET_ID: begin
                        if (({1'b0, obj_reg} >= oc_reg) || ({1'b0, t_reg} >= mc_reg)) begin
                            status_next = fcat_pkg::STAT_INVALID;
                        end else begin
                            id_addr  = obj_reg;
                            id_we    = 1'b1;
                            id_wdata = {1'b1, t_reg};
                        end
                    end
                    fcat_pkg::CMD_ADD_COMP: begin
                        if (({1'b0, g_reg} >= mc_reg) || ({1'b0, f_reg} >= mc_reg)
                            || ({1'b0, t_reg} >= mc_reg)) begin
                            status_next = fcat_pkg::STAT_INVALID;
                        end else if (cc_reg >= 11'(fcat_pkg::MAX_COMP)) begin
                            status_next = fcat_pkg::STAT_FULL;
                        end else begin
                            row_addr = cc_reg[9:0];
                            row_we   = 1'b1;
                            cc_next  = cc_reg + 11'd1;
                        end
                    end
                    fcat_pkg::CMD_VALIDATE, fcat_pkg::CMD_COMPOSE: begin
                    end
                    default: status_next = fcat_pkg::STAT_INVALID;
                endcase
            end
            fcat_pkg::S_OUT: m_axis_tvalid = 1'b1;
            fcat_pkg::S_CMP_A: begin
                row_addr = ia_reg[9:0];
                if (ia_ge_cc) status_next = fcat_pkg::STAT_INVALID;
            end
            fcat_pkg::S_CMP_B: begin
                if (row_hit) begin
                    found_next = 1'b1;
                    comp_next  = row_q[7:0];
                end else begin
                    ia_next = ia_reg + 11'd1;
                end
            end
            fcat_pkg::S_CLR: begin
                pair_addr = {ia_reg[7:0], ib_reg[7:0]};
                pair_we   = 1'b1;
                if (clr_f_last) begin
                    ib_next = '0;
                    ia_next = clr_g_last ? 11'd0 : ia_reg + 11'd1;
                end else begin
                    ib_next = ib_reg + 11'd1;
                end
            end
            fcat_pkg::S_ID_A: begin
                id_addr = ia_reg[5:0];
                if (ia_ge_oc) ia_next = '0;
            end
            fcat_pkg::S_ID_B: mor_addr = id_q[7:0];
            fcat_pkg::S_ID_C: ia_next = ia_reg + 11'd1;
            fcat_pkg::S_ROW_A: begin
                row_addr = ia_reg[9:0];
                if (ia_ge_cc) ia_next = '0;
            end
            fcat_pkg::S_ROW_B: begin
                tg_next  = row_q[23:16];
                tf_next  = row_q[15:8];
                tr_next  = row_q[7:0];
                mor_addr = row_q[15:8];
            end
            fcat_pkg::S_ROW_C: begin
                fdom_next = mor_q[11:6];
                fcod_next = mor_q[5:0];
                mor_addr  = tg_reg;
            end
            fcat_pkg::S_ROW_D: begin
                gcod_next = mor_q[5:0];
                mor_addr  = tr_reg;
            end
            fcat_pkg::S_ROW_E: pair_addr = {tg_reg, tf_reg};
            fcat_pkg::S_ROW_F: begin
                // saturating row count, first result kept
                pair_addr  = {tg_reg, tf_reg};
                pair_we    = 1'b1;
                pair_wdata = (pair_q[9:8] == 2'd0) ? {2'd1, tr_reg} : {2'd2, pair_q[7:0]};
                ia_next    = ia_reg + 11'd1;
            end
            fcat_pkg::S_PR_A: begin
                mor_addr = ia_reg[7:0];
                ib_next  = '0;
                if (ia_ge_mc) ia_next = '0;
            end
            fcat_pkg::S_PR_B: dg_next = mor_q[11:6];
            fcat_pkg::S_PR_C: begin
                mor_addr  = ib_reg[7:0];
                pair_addr = {ia_reg[7:0], ib_reg[7:0]};
                if (ib_ge_mc) ia_next = ia_reg + 11'd1;
            end
            fcat_pkg::S_PR_D: ib_next = ib_reg + 11'd1;
            fcat_pkg::S_AS_A: begin
                row_addr = ia_reg[9:0];
                if (ia_ge_cc) ia_next = '0;
            end
            fcat_pkg::S_AS_B: begin
                tg_next = row_q[23:16];
                tf_next = row_q[15:8];
                tr_next = row_q[7:0];
                ib_next = '0;
            end
            fcat_pkg::S_AS_C: begin
                row_addr = ib_reg[9:0];
                if (ib_ge_cc) ia_next = ia_reg + 11'd1;
            end
            fcat_pkg::S_AS_D: begin
                // row j composes after row i: compare (rj o f) with (h o ri)
                if (row_q[15:8] == tg_reg) begin
                    hj_next   = row_q[23:16];
                    pair_addr = {row_q[7:0], tf_reg};
                end else begin
                    ib_next = ib_reg + 11'd1;
                end
            end
            fcat_pkg::S_AS_E: begin
                ares_next = pair_q[7:0];
                pair_addr = {hj_reg, tr_reg};
            end
            fcat_pkg::S_AS_F: ib_next = ib_reg + 11'd1;
            fcat_pkg::S_IL_A: begin
                mor_addr = ia_reg[7:0];
                if (ia_ge_mc) valid_next = 1'b1;
            end
            fcat_pkg::S_IL_B: begin
                fdom_next = mor_q[11:6];
                id_addr   = mor_q[5:0];
            end
            fcat_pkg::S_IL_C: pair_addr = {id_q[7:0], ia_reg[7:0]};
            fcat_pkg::S_IL_D: id_addr = fdom_reg;
            fcat_pkg::S_IL_E: pair_addr = {ia_reg[7:0], id_q[7:0]};
            fcat_pkg::S_IL_F: ia_next = ia_reg + 11'd1;
            default: begin
            end
        endcase
    end

    assign m_axis_tdata = {4'd0, comp_reg, found_reg, valid_reg, new_id_reg, status_reg};

`ifndef SYNTHESIS
    a_oc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        oc_reg <= 7'(fcat_pkg::MAX_OBJ))
        else $error("object count beyond table size");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_axis_tvalid && s_axis_tready))
        else $error("request taken while result pending");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> state_reg == fcat_pkg::S_EXEC)
        else $error("accepted request not executed");

    a_counts_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != fcat_pkg::S_EXEC) |=> ($stable(mc_reg) && $stable(cc_reg)))
        else $error("table count changed outside command execution");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && found_reg) |-> status_reg == fcat_pkg::STAT_OK)
        else $error("found with failing status");
`endif

endmodule
